// File: hdl/olwd_pkg.sv
// ----------------------------------------------------------------------------
// olwd_pkg: shared types and constants for the ordered list block
// Request and result formats and the default list depth.
// ----------------------------------------------------------------------------
`default_nettype none

package olwd_pkg;

  localparam int LIST_DEPTH_DEF = 16;
  localparam int VALUE_W        = 32;
  localparam int MODE_W         = 2;
  localparam int COUNT_W        = 5;
  localparam int IN_TDATA_W     = 40;
  localparam int OUT_TDATA_W    = 40;

  typedef enum logic [1:0] {
    OP_APPEND,
    OP_DELETE,
    OP_POP,
    OP_CLEAR
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [VALUE_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic               hit;
    logic [VALUE_W-1:0] popped_value;
    logic               overflow;
    logic [COUNT_W-1:0] entry_count;
  } res_t;

endpackage

`default_nettype wire

// File: hdl/olwd_front.sv
// ----------------------------------------------------------------------------
// olwd_front: request intake
// Accepts requests, decodes the mode into an operation and holds them in a
// two-entry queue that the execution side drains at its own pace.
// ----------------------------------------------------------------------------
`default_nettype none

module olwd_front (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [olwd_pkg::MODE_W-1:0]      mode,
  input  wire logic [olwd_pkg::VALUE_W-1:0]     item_value,
  output logic                                  q_valid,
  output olwd_pkg::req_t                        q_req,
  input  wire logic                             q_pop
);

  localparam logic [1:0] QUEUE_FULL = 2'd2;

  olwd_pkg::req_t q_mem [2];
  olwd_pkg::req_t req_in;
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     cnt;
  logic           push;
  logic           take;

  // The mode field uses the same encoding as the operation type.
  always_comb begin
    req_in.op    = olwd_pkg::op_t'(mode);
    req_in.value = item_value;
  end

  assign in_ready = (cnt != QUEUE_FULL);
  assign q_valid  = (cnt != 2'd0);
  assign q_req    = q_mem[rd_ptr];
  assign push     = in_valid && in_ready;
  assign take     = q_pop && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (take) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, take})
        2'b10:   cnt <= cnt + 2'd1;
        2'b01:   cnt <= cnt - 2'd1;
        default: cnt <= cnt;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= req_in;
    end
  end

endmodule

`default_nettype wire

// File: hdl/olwd_back.sv
// ----------------------------------------------------------------------------
// olwd_back: list execution engine
// Holds the list as a row of cells, compares all cells against a value in
// the compare state and then commits append, delete, pop or clear.
// ----------------------------------------------------------------------------
`default_nettype none

module olwd_back #(
  parameter int LIST_DEPTH = olwd_pkg::LIST_DEPTH_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            q_valid,
  input  wire olwd_pkg::req_t  q_req,
  output logic                 q_pop,
  output logic                 res_valid,
  input  wire logic            res_ready,
  output olwd_pkg::res_t       res
);

  localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CW = $clog2(LIST_DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_COMMIT
  } state_t;

  state_t                       st;
  olwd_pkg::req_t               cur;
  logic [CW-1:0]                occ;
  logic [CW-1:0]                occ_next;
  logic [olwd_pkg::VALUE_W-1:0] entries [LIST_DEPTH];
  logic [LIST_DEPTH-1:0]        match;
  logic [LIST_DEPTH-1:0]        shift_sel;
  logic                         commit;
  logic                         full;
  logic                         empty;
  logic                         any_match;
  logic                         do_write;
  logic                         do_shift;
  olwd_pkg::res_t               res_next;

  assign commit    = (st == S_COMMIT) && (!res_valid || res_ready);
  assign q_pop     = q_valid && ((st == S_IDLE) || commit);
  assign full      = (occ == CW'(LIST_DEPTH));
  assign empty     = (occ == '0);
  assign any_match = |match;
  assign do_write  = commit && (cur.op == olwd_pkg::OP_APPEND) && !full;
  assign do_shift  = commit && (((cur.op == olwd_pkg::OP_DELETE) && any_match) ||
                                ((cur.op == olwd_pkg::OP_POP) && !empty));

  // A cell moves up when it sits at or after the first match; pop moves all.
  for (genvar gi = 0; gi < LIST_DEPTH; gi++) begin : g_cell
    assign shift_sel[gi] = (cur.op == olwd_pkg::OP_POP) || (|match[gi:0]);

    always_ff @(posedge clk) begin
      if (st == S_CMP) begin
        match[gi] <= (CW'(gi) < occ) && (entries[gi] == cur.value);
      end
    end

    if (gi < LIST_DEPTH - 1) begin : g_mid
      always_ff @(posedge clk) begin
        if (do_write && (occ[AW-1:0] == AW'(gi))) begin
          entries[gi] <= cur.value;
        end else if (do_shift && shift_sel[gi]) begin
          entries[gi] <= entries[gi+1];
        end
      end
    end else begin : g_last
      always_ff @(posedge clk) begin
        if (do_write && (occ[AW-1:0] == AW'(gi))) begin
          entries[gi] <= cur.value;
        end
      end
    end
  end

  always_comb begin
    occ_next              = occ;
    res_next.hit          = 1'b0;
    res_next.popped_value = '0;
    res_next.overflow     = 1'b0;
    case (cur.op)
      olwd_pkg::OP_APPEND: begin
        if (full) begin
          res_next.overflow = 1'b1;
        end else begin
          occ_next = occ + CW'(1);
        end
      end
      olwd_pkg::OP_DELETE: begin
        if (any_match) begin
          res_next.hit = 1'b1;
          occ_next     = occ - CW'(1);
        end
      end
      olwd_pkg::OP_POP: begin
        if (!empty) begin
          res_next.hit          = 1'b1;
          res_next.popped_value = entries[0];
          occ_next              = occ - CW'(1);
        end
      end
      default: begin
        occ_next = '0;
      end
    endcase
    res_next.entry_count = olwd_pkg::COUNT_W'(occ_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= S_IDLE;
      occ       <= '0;
      res_valid <= 1'b0;
    end else begin
      if (commit) begin
        occ       <= occ_next;
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
      case (st)
        S_IDLE: begin
          if (q_valid) begin
            st <= S_CMP;
          end
        end
        S_CMP: begin
          st <= S_COMMIT;
        end
        S_COMMIT: begin
          if (commit) begin
            st <= q_valid ? S_CMP : S_IDLE;
          end
        end
        default: begin
          st <= S_IDLE;
        end
      endcase
    end
    if (q_pop) begin
      cur <= q_req;
    end
    if (commit) begin
      res <= res_next;
    end
  end

endmodule

`default_nettype wire

// File: hdl/ordered_list_with_delete_by_value.sv
// ----------------------------------------------------------------------------
// ordered_list_with_delete_by_value: bounded insertion-ordered list
// Each request carries a mode and a value: append at the tail, delete the
// first entry equal to the value, pop the head, or clear the list. Every
// request yields exactly one result on the master stream.
//
// Channels: requests enter on s_tvalid/s_tready/s_tdata; results leave on
// m_tvalid/m_tready/m_tdata. Both complete on a cycle with valid and ready.
// A request passes through the queue into the engine, which compares it
// across the row of list cells, then commits it to the result register.
// The engine handles one request at a time and takes the next at commit.
// A two-entry request queue sits in front of the execution engine.
// Reset empties the list, the queue and the result register; the cell
// contents are left as they are and are never read before being written.
// When the receiver stalls, the result register holds its value, the engine
// waits in its commit step, the queue fills and s_tready then drops.
// ----------------------------------------------------------------------------
`default_nettype none

module ordered_list_with_delete_by_value #(
  parameter int LIST_DEPTH = olwd_pkg::LIST_DEPTH_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               s_tvalid,
  output logic                                    s_tready,
  // [1:0] mode, [33:2] item_value, [39:34] zero
  input  wire logic [olwd_pkg::IN_TDATA_W-1:0]    s_tdata,
  output logic                                    m_tvalid,
  input  wire logic                               m_tready,
  // [0] hit, [32:1] popped_value, [33] overflow, [38:34] entry_count, [39] zero
  output logic [olwd_pkg::OUT_TDATA_W-1:0]        m_tdata
);

  logic           q_valid;
  logic           q_pop;
  olwd_pkg::req_t q_req;
  olwd_pkg::res_t res;

  olwd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .mode       (s_tdata[1:0]),
    .item_value (s_tdata[33:2]),
    .q_valid    (q_valid),
    .q_req      (q_req),
    .q_pop      (q_pop)
  );

  olwd_back #(
    .LIST_DEPTH (LIST_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_req     (q_req),
    .q_pop     (q_pop),
    .res_valid (m_tvalid),
    .res_ready (m_tready),
    .res       (res)
  );

  assign m_tdata = {1'b0, res.entry_count, res.overflow, res.popped_value, res.hit};

endmodule

`default_nettype wire

// File: tb/ordered_list_with_delete_by_value_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ordered_list_with_delete_by_value_tb: self-checking bench for the list block
// A queue of requests feeds a clocked driver. Each request is run through a
// behavioral copy of the list when it is taken, and the predicted result is
// compared with the block's output as the monitor accepts it. Both sides stall
// at random. A directed opening covers empty, full and duplicate cases.
// Random phases with a small value pool follow, so that deletes often hit.
// ----------------------------------------------------------------------------
module ordered_list_with_delete_by_value_tb;

  localparam int DEPTH   = olwd_pkg::LIST_DEPTH_DEF;
  localparam int MAX_GAP = 5;
  localparam int VW      = olwd_pkg::VALUE_W;

  typedef struct {
    olwd_pkg::op_t op;
    logic [VW-1:0] value;
    int            gap;
    bit            drain;
  } list_req_t;

  logic                             clk      = 1'b0;
  logic                             rst      = 1'b1;
  logic                             s_tvalid = 1'b0;
  logic                             s_tready;
  logic [olwd_pkg::IN_TDATA_W-1:0]  s_tdata  = '0;
  logic                             m_tvalid;
  logic                             m_tready = 1'b0;
  logic [olwd_pkg::OUT_TDATA_W-1:0] m_tdata;

  list_req_t          req_queue[$];
  olwd_pkg::res_t     expected_results[$];
  list_req_t          held_req;
  logic [VW-1:0]      list_mem [DEPTH];
  int                 list_len   = 0;
  int                 req_total  = 0;
  int                 req_taken  = 0;
  int                 send_wait  = 0;
  int                 recv_wait  = 0;
  int                 calm_left  = 0;
  bit                 send_calm  = 1'b0;
  int                 err_cnt    = 0;
  olwd_pkg::res_t     got_res;
  olwd_pkg::res_t     want_res;

  ordered_list_with_delete_by_value #(
    .LIST_DEPTH(DEPTH)
  ) u_top (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  always #2 clk = ~clk;

  // Applies one request to the shadow list and queues the result it yields.
  task automatic predict_list_op(input olwd_pkg::op_t op, input logic [VW-1:0] v);
    olwd_pkg::res_t r;
    int             pos;
    int             i;
    r   = '0;
    pos = -1;
    case (op)
      olwd_pkg::OP_APPEND: begin
        if (list_len >= DEPTH) begin
          r.overflow = 1'b1;
        end else begin
          list_mem[list_len] = v;
          list_len++;
        end
      end
      olwd_pkg::OP_DELETE: begin
        for (i = 0; i < list_len; i++)
          if (pos < 0 && list_mem[i] == v) pos = i;
      end
      olwd_pkg::OP_POP: begin
        if (list_len > 0) begin
          pos            = 0;
          r.popped_value = list_mem[0];
        end
      end
      default: list_len = 0;
    endcase
    // A found entry is removed and everything behind it moves up one place.
    if (pos >= 0) begin
      r.hit = 1'b1;
      for (i = pos; i < list_len - 1; i++) list_mem[i] = list_mem[i + 1];
      list_len--;
    end
    r.entry_count = list_len[olwd_pkg::COUNT_W-1:0];
    expected_results.push_back(r);
  endtask

  task automatic add_req(input olwd_pkg::op_t op, input logic [VW-1:0] v, input bit drain);
    list_req_t q;
    q.op    = op;
    q.value = v;
    q.gap   = send_calm ? 0 : $urandom_range(0, MAX_GAP);
    q.drain = drain;
    req_queue.push_back(q);
    req_total++;
  endtask

  // Request driver.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        predict_list_op(held_req.op, held_req.value);
        req_taken++;
        send_wait = held_req.gap;
      end
      if (!s_tvalid || s_tready) begin
        if (send_wait > 0) begin
          send_wait--;
          s_tvalid <= 1'b0;
        end else if (req_queue.size() > 0 &&
                     (!req_queue[0].drain || expected_results.size() == 0)) begin
          held_req = req_queue.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= {{(olwd_pkg::IN_TDATA_W-VW-olwd_pkg::MODE_W){1'b0}},
                       held_req.value, held_req.op};
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got_res.hit          = m_tdata[0];
        got_res.popped_value = m_tdata[32:1];
        got_res.overflow     = m_tdata[33];
        got_res.entry_count  = m_tdata[38:34];
        if (expected_results.size() == 0) begin
          $display("%0t: result with no request pending: hit=%0b pop=%h ovf=%0b cnt=%0d",
                   $time, got_res.hit, got_res.popped_value, got_res.overflow,
                   got_res.entry_count);
          err_cnt++;
        end else begin
          want_res = expected_results.pop_front();
          if (got_res !== want_res) begin
            $display("%0t: expected hit=%0b pop=%h ovf=%0b cnt=%0d, got hit=%0b pop=%h ovf=%0b cnt=%0d",
                     $time, want_res.hit, want_res.popped_value, want_res.overflow,
                     want_res.entry_count, got_res.hit, got_res.popped_value,
                     got_res.overflow, got_res.entry_count);
            err_cnt++;
          end
        end
        if (calm_left > 0) begin
          calm_left--;
          recv_wait = 0;
        end else begin
          recv_wait = $urandom_range(0, MAX_GAP);
          if ($urandom_range(0, 29) == 0) calm_left = $urandom_range(10, 30);
        end
      end
      if (recv_wait > 0) begin
        recv_wait--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  initial begin
    logic [VW-1:0] pool [8];
    int            phase;
    int            k;
    int            r;
    int            append_pct;
    olwd_pkg::op_t op;
    logic [VW-1:0] v;

    // Empty list, then fill to the limit with both extremes and a duplicate.
    add_req(olwd_pkg::OP_POP, 32'h0000_0000, 1'b0);
    add_req(olwd_pkg::OP_DELETE, 32'h0000_0005, 1'b0);
    add_req(olwd_pkg::OP_APPEND, 32'h8000_0000, 1'b0);
    add_req(olwd_pkg::OP_APPEND, 32'h7FFF_FFFF, 1'b0);
    add_req(olwd_pkg::OP_APPEND, 32'h0000_0000, 1'b0);
    add_req(olwd_pkg::OP_APPEND, 32'hFFFF_FFFF, 1'b0);
    add_req(olwd_pkg::OP_APPEND, 32'h0000_0000, 1'b0);
    for (k = 0; k < DEPTH - 6; k++) add_req(olwd_pkg::OP_APPEND, $urandom, 1'b0);
    add_req(olwd_pkg::OP_APPEND, 32'h5555_AAAA, 1'b0);
    // The list is full now; the next append must be dropped.
    add_req(olwd_pkg::OP_APPEND, 32'h1234_5678, 1'b1);
    add_req(olwd_pkg::OP_DELETE, 32'h7FFF_FFFF, 1'b0);
    add_req(olwd_pkg::OP_DELETE, 32'hDEAD_BEEF, 1'b0);
    add_req(olwd_pkg::OP_DELETE, 32'h0000_0000, 1'b0);
    add_req(olwd_pkg::OP_POP, 32'hFFFF_FFFF, 1'b0);
    add_req(olwd_pkg::OP_DELETE, 32'h5555_AAAA, 1'b0);
    add_req(olwd_pkg::OP_CLEAR, 32'hFFFF_FFFF, 1'b0);
    add_req(olwd_pkg::OP_POP, 32'h0000_0000, 1'b0);
    add_req(olwd_pkg::OP_CLEAR, 32'h0000_0000, 1'b0);

    // Random phases alternate between filling and draining the list.
    for (phase = 0; phase < 12; phase++) begin
      send_calm  = (phase % 3 == 2);
      append_pct = (phase % 2 == 0) ? 65 : 35;
      pool[0]    = 32'h8000_0000;
      pool[1]    = 32'h7FFF_FFFF;
      pool[2]    = 32'h0000_0000;
      for (k = 3; k < 8; k++) pool[k] = $urandom;
      for (k = 0; k < 40; k++) begin
        r = $urandom_range(0, 99);
        if (r < 3) op = olwd_pkg::OP_CLEAR;
        else if (r < 3 + append_pct) op = olwd_pkg::OP_APPEND;
        else if (r < 3 + append_pct + (97 - append_pct) * 3 / 5) op = olwd_pkg::OP_DELETE;
        else op = olwd_pkg::OP_POP;
        v = ($urandom_range(0, 3) == 0) ? $urandom : pool[$urandom_range(0, 7)];
        add_req(op, v, (phase == 6 && k == 0));
      end
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    while (req_taken < req_total || expected_results.size() > 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (err_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// File: files.f
hdl/olwd_pkg.sv
hdl/olwd_front.sv
hdl/olwd_back.sv
hdl/ordered_list_with_delete_by_value.sv
tb/ordered_list_with_delete_by_value_tb.sv
